// File: rtl/odq_pkg.sv
// ----------------------------------------------------------------------------
// odq_pkg
// Shared types and constant tables for the ordered dither palette quantizer:
// word layouts, the fixed palette and the 4x4 threshold matrix.
// ----------------------------------------------------------------------------
package odq_pkg;

   localparam int PaletteEntries = 16;
   localparam int IndexBits      = $clog2(PaletteEntries);
   localparam int MatrixSide     = 4;
   localparam int MatrixBits     = $clog2(MatrixSide);
   localparam int DistBits       = 20;

   typedef struct packed {
      logic [7:0]  red_in;
      logic [7:0]  green_in;
      logic [7:0]  blue_in;
      logic [11:0] column;
      logic [11:0] row;
   } req_type;

   typedef struct packed {
      logic [3:0] colour_index;
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } rsp_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // Word passed from cell to cell: dithered pixel plus best match so far.
   typedef struct packed {
      logic                 valid;
      pixel_type            pix;
      logic [DistBits-1:0]  distance;
      logic [IndexBits-1:0] idx;
   } link_type;

   localparam logic [23:0] PaletteTable [PaletteEntries] = '{
      24'h140C1C, 24'h442434, 24'h30346D, 24'h4E4A4E,
      24'h854C30, 24'h346524, 24'hD04648, 24'h757161,
      24'h597DCE, 24'hD27D2C, 24'h8595A1, 24'h6DAA2C,
      24'hD2AA99, 24'h6DC2CA, 24'hDAD45E, 24'hDEEED6
   };

   // Indexed by {column, row} low bits, column major.
   localparam logic [3:0] ThresholdTable [MatrixSide*MatrixSide] = '{
      4'd0,  4'd8,  4'd2,  4'd10,
      4'd12, 4'd4,  4'd14, 4'd6,
      4'd3,  4'd11, 4'd1,  4'd9,
      4'd15, 4'd7,  4'd13, 4'd5
   };

endpackage

// File: rtl/odq_cell.sv
// ----------------------------------------------------------------------------
// odq_cell
// One palette cell: measures the redmean distance from the passing pixel to
// its own palette colour and keeps the better of that and the incoming best.
// ----------------------------------------------------------------------------
module odq_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  odq_pkg::link_type link_in,
   output odq_pkg::link_type link_out
);
   import odq_pkg::*;

   localparam logic [23:0] Colour = PaletteTable[CELL_INDEX];
   localparam logic [IndexBits-1:0] MyIndex = IndexBits'(CELL_INDEX);

   // first stage: squares and mean
   logic                 a_valid_ff, a_valid_in;
   pixel_type            a_pix_ff;
   logic [DistBits-1:0]  a_dist_ff;
   logic [IndexBits-1:0] a_idx_ff;
   logic [15:0]          sq_r_ff, sq_g_ff, sq_b_ff;
   logic [15:0]          sq_r_in, sq_g_in, sq_b_in;
   logic [7:0]           mean_ff, mean_in;
   logic [7:0]           dr, dg, db;
   logic [8:0]           red_sum;

   // second stage: distance and compare
   logic                 b_valid_ff;
   pixel_type            b_pix_ff;
   logic [DistBits-1:0]  b_dist_ff, b_dist_in;
   logic [IndexBits-1:0] b_idx_ff, b_idx_in;
   logic [9:0]           red_weight, blue_weight;
   logic [25:0]          red_prod, blue_prod;
   logic [DistBits-1:0]  cell_distance;

   always_comb begin
      dr = (link_in.pix.red > Colour[23:16]) ? link_in.pix.red - Colour[23:16]
                                             : Colour[23:16] - link_in.pix.red;
      dg = (link_in.pix.green > Colour[15:8]) ? link_in.pix.green - Colour[15:8]
                                              : Colour[15:8] - link_in.pix.green;
      db = (link_in.pix.blue > Colour[7:0]) ? link_in.pix.blue - Colour[7:0]
                                            : Colour[7:0] - link_in.pix.blue;
      sq_r_in    = 16'(dr) * 16'(dr);
      sq_g_in    = 16'(dg) * 16'(dg);
      sq_b_in    = 16'(db) * 16'(db);
      red_sum    = {1'b0, link_in.pix.red} + {1'b0, Colour[23:16]};
      mean_in    = red_sum[8:1];
      a_valid_in = link_in.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_pix_ff  <= link_in.pix;
         a_dist_ff <= link_in.distance;
         a_idx_ff  <= link_in.idx;
         sq_r_ff   <= sq_r_in;
         sq_g_ff   <= sq_g_in;
         sq_b_ff   <= sq_b_in;
         mean_ff   <= mean_in;
      end
   end

   always_comb begin
      red_weight    = 10'd512 + {2'b00, mean_ff};
      blue_weight   = 10'd767 - {2'b00, mean_ff};
      red_prod      = 26'(red_weight) * 26'(sq_r_ff);
      blue_prod     = 26'(blue_weight) * 26'(sq_b_ff);
      cell_distance = DistBits'(red_prod[25:8]) + DistBits'({sq_g_ff, 2'b00})
                    + DistBits'(blue_prod[25:8]);
      // ties go to the later, higher index
      if (cell_distance <= a_dist_ff) begin
         b_dist_in = cell_distance;
         b_idx_in  = MyIndex;
      end else begin
         b_dist_in = a_dist_ff;
         b_idx_in  = a_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_pix_ff  <= a_pix_ff;
         b_dist_ff <= b_dist_in;
         b_idx_ff  <= b_idx_in;
      end
   end

   assign link_out.valid    = b_valid_ff;
   assign link_out.pix      = b_pix_ff;
   assign link_out.distance = b_dist_ff;
   assign link_out.idx      = b_idx_ff;

   assert property (@(posedge clock) disable iff (reset)
      !advance |=> (b_valid_ff == $past(b_valid_ff)))
      else $error("cell output valid moved during a stall");

   assert property (@(posedge clock) disable iff (reset)
      advance |=> (b_valid_ff == $past(a_valid_ff)))
      else $error("cell lost or invented a word");

   assert property (@(posedge clock) disable iff (reset)
      (advance && a_valid_ff) |=> (b_dist_ff <= $past(a_dist_ff)))
      else $error("best distance grew across a cell");

   assert property (@(posedge clock) disable iff (reset)
      (advance && a_valid_ff) |=> ((b_idx_ff == MyIndex) || (b_idx_ff == $past(a_idx_ff))))
      else $error("cell produced a foreign index");

endmodule

// File: rtl/ordered_dither_palette_quantizer_unit.sv
// ----------------------------------------------------------------------------
// ordered_dither_palette_quantizer_unit
// Bayer 4x4 ordered dither followed by nearest palette colour search.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock when not stalled and returns one result word
// per pixel, in order. A dither stage adds fifteen times the Bayer threshold
// to each channel (saturating at 255), then the pixel walks a row of sixteen
// palette cells, one per palette colour, each two registers deep, collecting
// the nearest colour by redmean distance (ties go to the higher index). A pixel
// passes 33 registers, the dither register and two per cell, before its result
// word is offered; throughput is one pixel per clock while rsp_ready does not
// hold the output. The whole row holds while a result waits on rsp_ready, so
// req_ready follows the output.
module ordered_dither_palette_quantizer_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  odq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output odq_pkg::rsp_type rsp_data
);
   import odq_pkg::*;

   logic                  advance;
   link_type              front_link;
   logic                  front_valid_ff;
   pixel_type             front_pix_ff, front_pix_in;
   logic [3:0]            thresh;
   logic [7:0]            offset;
   logic [8:0]            sum_r, sum_g, sum_b;
   link_type              link [PaletteEntries+1];
   logic [23:0]           chosen;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      thresh = ThresholdTable[{req_data.column[MatrixBits-1:0],
                               req_data.row[MatrixBits-1:0]}];
      offset = {thresh, 4'b0000} - {4'b0000, thresh};
      sum_r  = {1'b0, req_data.red_in} + {1'b0, offset};
      sum_g  = {1'b0, req_data.green_in} + {1'b0, offset};
      sum_b  = {1'b0, req_data.blue_in} + {1'b0, offset};
      front_pix_in.red   = sum_r[8] ? 8'hFF : sum_r[7:0];
      front_pix_in.green = sum_g[8] ? 8'hFF : sum_g[7:0];
      front_pix_in.blue  = sum_b[8] ? 8'hFF : sum_b[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (advance) begin
         front_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         front_pix_ff <= front_pix_in;
      end
   end

   // seed the best distance above any real distance
   always_comb begin
      front_link.valid    = front_valid_ff;
      front_link.pix      = front_pix_ff;
      front_link.distance = '1;
      front_link.idx      = '0;
   end

   assign link[0] = front_link;

   for (genvar k = 0; k < PaletteEntries; k++) begin : g_cell
      odq_cell #(
         .CELL_INDEX(k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .link_in  (link[k]),
         .link_out (link[k+1])
      );
   end

   assign chosen    = PaletteTable[link[PaletteEntries].idx];
   assign rsp_valid = link[PaletteEntries].valid;

   always_comb begin
      rsp_data.colour_index = link[PaletteEntries].idx;
      rsp_data.red_out      = chosen[23:16];
      rsp_data.green_out    = chosen[15:8];
      rsp_data.blue_out     = chosen[7:0];
   end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Standalone bench for the ordered dither palette quantizer. It offers pixel
// words with random gaps, holds off the result side at random, and checks each
// result word in order against a predictor of the dither and redmean search.
// ----------------------------------------------------------------------------
module tb_top;
   import odq_pkg::*;

   localparam int DitherStep  = 255 / 17;
   localparam int RandomItems = 626;
   localparam int HoldAt      = 160;
   localparam int HoldOff     = 150;
   localparam int QuietLimit  = 2000;
   localparam int Settle      = 40;

   // Bench copy of the build-time palette, {red, green, blue}.
   localparam logic [23:0] Swatch [16] = '{
      24'h140C1C, 24'h442434, 24'h30346D, 24'h4E4A4E,
      24'h854C30, 24'h346524, 24'hD04648, 24'h757161,
      24'h597DCE, 24'hD27D2C, 24'h8595A1, 24'h6DAA2C,
      24'hD2AA99, 24'h6DC2CA, 24'hDAD45E, 24'hDEEED6
   };

   // Bayer thresholds, indexed by {column[1:0], row[1:0]}.
   localparam logic [3:0] Bayer [16] = '{
      4'd0,  4'd8,  4'd2,  4'd10,
      4'd12, 4'd4,  4'd14, 4'd6,
      4'd3,  4'd11, 4'd1,  4'd9,
      4'd15, 4'd7,  4'd13, 4'd5
   };

   typedef struct packed {
      req_type px;
      logic    known;
      rsp_type want;
   } probe_row_type;

   // Rows with known set carry a result read straight off the palette.
   localparam int NumProbes = 24;
   localparam probe_row_type Probes [NumProbes] = '{
      '{'{8'd20,  8'd12,  8'd28,  12'h000, 12'h000}, 1'b1, '{4'd0,  8'd20,  8'd12,  8'd28}},
      '{'{8'd68,  8'd36,  8'd52,  12'hFFC, 12'hFFC}, 1'b1, '{4'd1,  8'd68,  8'd36,  8'd52}},
      '{'{8'd48,  8'd52,  8'd109, 12'h554, 12'hAA8}, 1'b1, '{4'd2,  8'd48,  8'd52,  8'd109}},
      '{'{8'd78,  8'd74,  8'd78,  12'hAA8, 12'h554}, 1'b1, '{4'd3,  8'd78,  8'd74,  8'd78}},
      '{'{8'd133, 8'd76,  8'd48,  12'h3F0, 12'h00C}, 1'b1, '{4'd4,  8'd133, 8'd76,  8'd48}},
      '{'{8'd52,  8'd101, 8'd36,  12'h004, 12'h800}, 1'b1, '{4'd5,  8'd52,  8'd101, 8'd36}},
      '{'{8'd208, 8'd70,  8'd72,  12'h800, 12'h3F0}, 1'b1, '{4'd6,  8'd208, 8'd70,  8'd72}},
      '{'{8'd117, 8'd113, 8'd97,  12'h010, 12'hFF0}, 1'b1, '{4'd7,  8'd117, 8'd113, 8'd97}},
      '{'{8'd89,  8'd125, 8'd206, 12'hF0C, 12'h0F4}, 1'b1, '{4'd8,  8'd89,  8'd125, 8'd206}},
      '{'{8'd210, 8'd125, 8'd44,  12'h0F4, 12'hF0C}, 1'b1, '{4'd9,  8'd210, 8'd125, 8'd44}},
      '{'{8'd133, 8'd149, 8'd161, 12'h100, 12'h200}, 1'b1, '{4'd10, 8'd133, 8'd149, 8'd161}},
      '{'{8'd109, 8'd170, 8'd44,  12'h400, 12'h100}, 1'b1, '{4'd11, 8'd109, 8'd170, 8'd44}},
      '{'{8'd210, 8'd170, 8'd153, 12'h020, 12'h040}, 1'b1, '{4'd12, 8'd210, 8'd170, 8'd153}},
      '{'{8'd109, 8'd194, 8'd202, 12'h080, 12'h020}, 1'b1, '{4'd13, 8'd109, 8'd194, 8'd202}},
      '{'{8'd218, 8'd212, 8'd94,  12'h008, 12'h400}, 1'b1, '{4'd14, 8'd218, 8'd212, 8'd94}},
      '{'{8'd222, 8'd238, 8'd214, 12'h200, 12'h008}, 1'b1, '{4'd15, 8'd222, 8'd238, 8'd214}},
      '{'{8'd0,   8'd0,   8'd0,   12'h000, 12'h000}, 1'b1, '{4'd0,  8'd20,  8'd12,  8'd28}},
      '{'{8'd255, 8'd255, 8'd255, 12'h000, 12'h000}, 1'b1, '{4'd15, 8'd222, 8'd238, 8'd214}},
      // Saturation: the largest threshold pushes high channels over the top.
      '{'{8'd255, 8'd255, 8'd255, 12'h003, 12'h000}, 1'b0, '0},
      '{'{8'd250, 8'd10,  8'd200, 12'h003, 12'h000}, 1'b0, '0},
      '{'{8'd0,   8'd0,   8'd0,   12'h003, 12'h000}, 1'b0, '0},
      // Wide positions: only the low two bits pick the threshold.
      '{'{8'd255, 8'd255, 8'd255, 12'hFFF, 12'hFFF}, 1'b0, '0},
      '{'{8'd31,  8'd255, 8'd0,   12'h801, 12'h002}, 1'b0, '0},
      '{'{8'd200, 8'd100, 8'd50,  12'h7FE, 12'hFFD}, 1'b0, '0}
   };

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type want_next = '0;
   rsp_type pending [$];
   int      pixels_in = 0;
   int      errors    = 0;

   ordered_dither_palette_quantizer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Dither the pixel, then pick the nearest swatch by redmean distance.
   function automatic rsp_type quantize(input req_type px);
      int unsigned lift, r, g, b, pr, pg, pb, m, dr, dg, db, metric, best, pick;
      rsp_type res;
      lift = Bayer[{px.column[1:0], px.row[1:0]}] * DitherStep;
      r = px.red_in + lift;
      g = px.green_in + lift;
      b = px.blue_in + lift;
      r = (r > 255) ? 255 : r;
      g = (g > 255) ? 255 : g;
      b = (b > 255) ? 255 : b;
      best = 0;
      pick = 0;
      for (int k = 0; k < 16; k++) begin
         pr = Swatch[k][23:16];
         pg = Swatch[k][15:8];
         pb = Swatch[k][7:0];
         m  = (r + pr) >> 1;
         dr = (r > pr) ? r - pr : pr - r;
         dg = (g > pg) ? g - pg : pg - g;
         db = (b > pb) ? b - pb : pb - b;
         metric = (((512 + m) * dr * dr) >> 8) + 4 * dg * dg
                + (((767 - m) * db * db) >> 8);
         // Equal distance moves the pick up to the higher index.
         if (k == 0 || metric <= best) begin
            best = metric;
            pick = k;
         end
      end
      res.colour_index = pick[3:0];
      res.red_out      = Swatch[pick][23:16];
      res.green_out    = Swatch[pick][15:8];
      res.blue_out     = Swatch[pick][7:0];
      return res;
   endfunction

   // Mostly short gaps, some none, a few long.
   function automatic int idle_span();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Palette channel shifted back by the dither and jittered a little.
   function automatic logic [7:0] nudge(input int base, input int lift);
      int v;
      v = base - lift + $urandom_range(0, 12) - 6;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   task automatic report_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   task automatic offer_pixel(input req_type px, input rsp_type want, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      want_next <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and hold until every pixel in flight has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending.size() != 0);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending.size() == 0) begin
               errors++;
               $display("%0t: result word expected none actual %p", $time, rsp_data);
            end else begin
               want = pending.pop_front();
               report_field("colour_index", 8'(want.colour_index), 8'(rsp_data.colour_index));
               report_field("red_out", want.red_out, rsp_data.red_out);
               report_field("green_out", want.green_out, rsp_data.green_out);
               report_field("blue_out", want.blue_out, rsp_data.blue_out);
            end
         end
         if (req_valid && req_ready) begin
            pending.push_back(want_next);
            pixels_in <= pixels_in + 1;
         end
      end
   end

   initial begin : result_side
      int span;
      bit held;
      held = 1'b0;
      forever begin
         if (!held && pixels_in >= HoldAt) begin
            // Hold off long enough for the pipeline to fill and back up.
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HoldOff) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
            repeat (span) @(posedge clock);
            span = idle_span();
            if (span > 0) begin
               rsp_ready <= 1'b0;
               repeat (span) @(posedge clock);
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QuietLimit) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("** ordered_dither_palette_quantizer_unit: FAILED **");
      $finish;
   end

   initial begin : pixel_side
      req_type px;
      rsp_type want;
      int      gap, mode, k, lift;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NumProbes; i++) begin
         want = Probes[i].known ? Probes[i].want : quantize(Probes[i].px);
         offer_pixel(Probes[i].px, want, idle_span());
      end
      drain();

      for (int n = 0; n < RandomItems; n++) begin
         px.column = 12'($urandom_range(0, 4095));
         px.row    = 12'($urandom_range(0, 4095));
         mode = $urandom_range(0, 99);
         if (mode < 55) begin
            // Land near a swatch after dither, where nearest picks are close calls.
            k    = $urandom_range(0, 15);
            lift = Bayer[{px.column[1:0], px.row[1:0]}] * DitherStep;
            px.red_in   = nudge(Swatch[k][23:16], lift);
            px.green_in = nudge(Swatch[k][15:8], lift);
            px.blue_in  = nudge(Swatch[k][7:0], lift);
         end else if (mode < 90) begin
            px.red_in   = 8'($urandom_range(0, 255));
            px.green_in = 8'($urandom_range(0, 255));
            px.blue_in  = 8'($urandom_range(0, 255));
         end else begin
            px.red_in   = 8'($urandom_range(180, 255));
            px.green_in = 8'($urandom_range(180, 255));
            px.blue_in  = 8'($urandom_range(180, 255));
         end
         // Offer back to back across the receiver hold-off, and in bursts elsewhere.
         if ((n >= 100 && n < 360) || (n / 30) % 4 == 1)
            gap = 0;
         else
            gap = idle_span();
         offer_pixel(px, quantize(px), gap);
         if (n == 420)
            drain();
      end

      drain();
      repeat (Settle) @(posedge clock);
      if (errors == 0)
         $display("** ordered_dither_palette_quantizer_unit: PASSED **");
      else
         $display("** ordered_dither_palette_quantizer_unit: FAILED **");
      $finish;
   end

endmodule
